[rtl/core/dhcm_pkg.sv]
// Package for the displacement hue colour map: defaults, scale constants,
// register and sector codes, and the structs passed between pipeline parts.
// No dependencies.
`default_nettype none

package dhcm_pkg;

  localparam int COORD_BITS_DEF    = 32;
  localparam int HUE_FRAC_BITS_DEF = 8;
  localparam int CFG_IDX_W         = 1;

  // Register reset values, Q15.16 at the default width (-0.5 and +0.5)
  localparam int RANGE_LOW_RST  = -32768;
  localparam int RANGE_HIGH_RST = 32768;

  // Integer bits of the position quotient (position stays below 512)
  localparam int POS_INT_BITS = 9;
  localparam int POS_MAX_DEG  = 359;
  localparam int HUE_BLUE_DEG = 240;
  localparam int SCALE_DEG    = 240;
  localparam int SECTOR_DEG   = 60;
  localparam int COLOUR_MAX   = 255;

  // floor(z / 15) = (z * RECIP_15) >> RECIP_SHIFT for z below 3826
  localparam int RECIP_15    = 4370;
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 16;
  localparam int QUARTER_SH  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANGE_LOW  = 1'b0,
    REG_RANGE_HIGH = 1'b1
  } dhcm_reg_e;

  typedef enum logic [2:0] {
    SECT_RED_YEL = 3'd0,
    SECT_YEL_GRN = 3'd1,
    SECT_GRN_CYN = 3'd2,
    SECT_CYN_BLU = 3'd3,
    SECT_BLU_MAG = 3'd4,
    SECT_MAG_RED = 3'd5
  } dhcm_sect_e;

  typedef struct packed {
    logic vld;
    logic zero;
    logic sat;
  } dhcm_ctl_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } dhcm_rgb_t;

endpackage

`default_nettype wire

[rtl/core/dhcm_front.sv]
// Front stages: saturated coordinate difference, offset from the low end
// scaled by 240, and the saturation check against 359 spans. Uses dhcm_pkg.
`default_nettype none

module dhcm_front import dhcm_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   vld_i,
  input  logic [COORD_BITS-1:0]  ref_x_i,
  input  logic [COORD_BITS-1:0]  off_x_i,
  input  logic [COORD_BITS:0]    low_i,
  input  logic [COORD_BITS:0]    span_i,
  input  logic [COORD_BITS+9:0]  span359_i,
  output dhcm_ctl_t              ctl_o,
  output logic [COORD_BITS+8:0]  num_o
);

  localparam int CB   = COORD_BITS;
  localparam int NUMW = COORD_BITS + 9;

  logic [CB:0]     diff;
  logic [CB-1:0]   d_d, d_q;
  logic [CB+1:0]   n;
  logic [NUMW-1:0] scaled;
  logic            zero2_d, sat3_d;
  logic [NUMW-1:0] num2_d, num2_q, num3_q;
  logic            vld1_q, vld2_q, vld3_q;
  logic            zero2_q, zero3_q, sat3_q;

  // stage 1: difference, saturated to the coordinate range
  assign diff = {ref_x_i[CB-1], ref_x_i} - {off_x_i[CB-1], off_x_i};

  always_comb begin
    if (diff[CB] != diff[CB-1]) begin
      d_d = diff[CB] ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
    end else begin
      d_d = diff[CB-1:0];
    end
  end

  // stage 2: offset from the low end, times 240
  assign n       = {{2{d_q[CB-1]}}, d_q} - {low_i[CB], low_i};
  assign zero2_d = (span_i == '0) || n[CB+1] || (n == '0);
  assign scaled  = ({8'd0, n[CB:0]} << 8) - ({8'd0, n[CB:0]} << 4);
  assign num2_d  = zero2_d ? '0 : scaled;

  // stage 3: position would reach 359 or more
  assign sat3_d = {1'b0, num2_q} >= span359_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q     <= d_d;
      num2_q  <= num2_d;
      zero2_q <= zero2_d;
      num3_q  <= num2_q;
      zero3_q <= zero2_q;
      sat3_q  <= sat3_d;
    end
  end

  assign ctl_o.vld  = vld3_q;
  assign ctl_o.zero = zero3_q;
  assign ctl_o.sat  = sat3_q;
  assign num_o      = num3_q;

endmodule

`default_nettype wire

[rtl/core/dhcm_div.sv]
// Pipelined restoring divider: one quotient bit per stage, nine integer
// bits then the hue fraction bits of (240*n) / span. Uses dhcm_pkg.
`default_nettype none

module dhcm_div import dhcm_pkg::*; #(
  parameter int COORD_BITS    = COORD_BITS_DEF,
  parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  dhcm_ctl_t                             ctl_i,
  input  logic [COORD_BITS+8:0]                 num_i,
  input  logic [COORD_BITS:0]                   span_i,
  output dhcm_ctl_t                             ctl_o,
  output logic [POS_INT_BITS+HUE_FRAC_BITS-1:0] quo_o
);

  localparam int QB = POS_INT_BITS + HUE_FRAC_BITS;
  localparam int RW = COORD_BITS + 10;

  dhcm_ctl_t       ctl_q [QB];
  logic [RW-1:0]   rem_q [QB];
  logic [QB-1:0]   quo_q [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    dhcm_ctl_t     ctl_in;
    logic [RW-1:0] rem_in, trial, divs;
    logic [QB-1:0] quo_in;
    logic          take;

    if (k == 0) begin : g_first
      assign ctl_in = ctl_i;
      assign rem_in = RW'(num_i);
      assign quo_in = '0;
    end else begin : g_next
      assign ctl_in = ctl_q[k-1];
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    // integer bits compare against the shifted span, fraction bits shift
    // the remainder instead
    if (k < POS_INT_BITS) begin : g_int
      assign trial = rem_in;
      assign divs  = RW'(span_i) << (POS_INT_BITS - 1 - k);
    end else begin : g_frac
      assign trial = rem_in << 1;
      assign divs  = RW'(span_i);
    end

    assign take = trial >= divs;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[k] <= '0;
      end else if (en_i) begin
        ctl_q[k] <= ctl_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= take ? trial - divs : trial;
        quo_q[k] <= {quo_in[QB-2:0], take};
      end
    end
  end

  assign ctl_o = ctl_q[QB-1];
  assign quo_o = quo_q[QB-1];

endmodule

`default_nettype wire

[rtl/core/dhcm_rgb.sv]
// Hue and colour stages: position to hue, sector split, scaled ramps and
// the sector selection of red, green and blue. Uses dhcm_pkg.
`default_nettype none

module dhcm_rgb import dhcm_pkg::*; #(
  parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  dhcm_ctl_t                             ctl_i,
  input  logic [POS_INT_BITS+HUE_FRAC_BITS-1:0] quo_i,
  output logic                                  vld_o,
  output dhcm_rgb_t                             rgb_o
);

  localparam int F    = HUE_FRAC_BITS;
  localparam int QB   = POS_INT_BITS + HUE_FRAC_BITS;
  localparam int HW   = HUE_FRAC_BITS + 8;
  localparam int REMW = HUE_FRAC_BITS + 6;
  localparam int PW   = REMW + 8;
  localparam int ZW   = PW - HUE_FRAC_BITS - QUARTER_SH;
  localparam int RPW  = ZW + RECIP_W;

  localparam logic [QB-1:0]   POS_SAT  = QB'(POS_MAX_DEG) << F;
  localparam logic [QB-1:0]   POS_BASE = QB'(HUE_BLUE_DEG) << F;
  localparam logic [HW-1:0]   SEC1     = HW'(SECTOR_DEG) << F;
  localparam logic [HW-1:0]   SEC2     = HW'(2 * SECTOR_DEG) << F;
  localparam logic [HW-1:0]   SEC3     = HW'(3 * SECTOR_DEG) << F;
  localparam logic [HW-1:0]   SEC4     = HW'(4 * SECTOR_DEG) << F;
  localparam logic [REMW-1:0] SEC_W    = REMW'(SECTOR_DEG) << F;

  logic [QB-1:0]   pos_sel;
  logic [HW-1:0]   hue1_d, hue1_q;
  dhcm_sect_e      sect2_d, sect2_q, sect3_q;
  logic [REMW-1:0] rem2_d, rem2_q;
  logic [PW-1:0]   up_prod, dn_prod;
  logic [ZW-1:0]   zt3_q, zq3_q;
  logic [RPW-1:0]  t_prod, q_prod;
  logic [7:0]      t_val, q_val;
  logic            vld1_q, vld2_q, vld3_q;

  // stage 1: hue = 240 - position, floored at zero; never above 240
  always_comb begin
    if (ctl_i.zero) begin
      pos_sel = '0;
    end else if (ctl_i.sat) begin
      pos_sel = POS_SAT;
    end else begin
      pos_sel = quo_i;
    end
    hue1_d = (pos_sel >= POS_BASE) ? '0 : HW'(POS_BASE - pos_sel);
  end

  // stage 2: sector and remainder within it
  always_comb begin
    if (hue1_q >= SEC4) begin
      sect2_d = SECT_BLU_MAG;
      rem2_d  = REMW'(hue1_q - SEC4);
    end else if (hue1_q >= SEC3) begin
      sect2_d = SECT_CYN_BLU;
      rem2_d  = REMW'(hue1_q - SEC3);
    end else if (hue1_q >= SEC2) begin
      sect2_d = SECT_GRN_CYN;
      rem2_d  = REMW'(hue1_q - SEC2);
    end else if (hue1_q >= SEC1) begin
      sect2_d = SECT_YEL_GRN;
      rem2_d  = REMW'(hue1_q - SEC1);
    end else begin
      sect2_d = SECT_RED_YEL;
      rem2_d  = REMW'(hue1_q);
    end
  end

  // stage 3: ramps times 255, dropping the fraction and a factor of four
  assign up_prod = PW'(rem2_q) * PW'(COLOUR_MAX);
  assign dn_prod = PW'(SEC_W - rem2_q) * PW'(COLOUR_MAX);

  // stage 4: divide by 15 through the reciprocal, then pick channels
  assign t_prod = RPW'(zt3_q) * RPW'(RECIP_15);
  assign q_prod = RPW'(zq3_q) * RPW'(RECIP_15);
  assign t_val  = t_prod[RECIP_SHIFT+7:RECIP_SHIFT];
  assign q_val  = q_prod[RECIP_SHIFT+7:RECIP_SHIFT];

  always_comb begin
    rgb_o = '0;
    case (sect3_q)
      SECT_RED_YEL: begin
        rgb_o.red   = 8'(COLOUR_MAX);
        rgb_o.green = t_val;
      end
      SECT_YEL_GRN: begin
        rgb_o.red   = q_val;
        rgb_o.green = 8'(COLOUR_MAX);
      end
      SECT_GRN_CYN: begin
        rgb_o.green = 8'(COLOUR_MAX);
        rgb_o.blue  = t_val;
      end
      SECT_CYN_BLU: begin
        rgb_o.green = q_val;
        rgb_o.blue  = 8'(COLOUR_MAX);
      end
      SECT_BLU_MAG: begin
        rgb_o.red   = t_val;
        rgb_o.blue  = 8'(COLOUR_MAX);
      end
      default: begin
        rgb_o.red   = 8'(COLOUR_MAX);
        rgb_o.blue  = q_val;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= ctl_i.vld;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hue1_q  <= hue1_d;
      sect2_q <= sect2_d;
      rem2_q  <= rem2_d;
      sect3_q <= sect2_q;
      zt3_q   <= up_prod[PW-1:F+QUARTER_SH];
      zq3_q   <= dn_prod[PW-1:F+QUARTER_SH];
    end
  end

  assign vld_o = vld3_q;

endmodule

`default_nettype wire

[rtl/core/displacement_hue_colour_map_core.sv]
// Top level of the displacement hue colour map: range registers, the
// front, divider and colour pipeline parts, and the output register with
// its skid slot. Uses dhcm_pkg, dhcm_front, dhcm_div and dhcm_rgb.
//
//   channel  direction  handshake                    payload
//   s_axis   in         s_axis_tvalid/s_axis_tready  reference_x, offset_x
//   m_axis   out        m_axis_tvalid/m_axis_tready  red, green, blue
//   cfg      in         cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
// One item enters per clock while s_axis_tready is high. From accept to
// m_axis_tvalid an item passes three front stages, one
// divider stage per quotient bit (9 + HUE_FRAC_BITS), three colour stages
// and the output register. The divider depth sets the latency.
// Reset clears all valid bits and loads the range registers with -0.5 and
// +0.5; the derived span registers follow, span_q first, then span359_q.
// A stall on m_axis parks one result in the skid slot, then freezes the
// whole pipeline; s_axis_tready comes straight from a flop.
`default_nettype none

module displacement_hue_colour_map_core import dhcm_pkg::*; #(
  parameter int COORD_BITS    = COORD_BITS_DEF,
  parameter int HUE_FRAC_BITS = HUE_FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // stream in
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [COORD_BITS-1:0] reference_x, [2*COORD_BITS-1:COORD_BITS] offset_x,
  // zero padding to whole bytes above
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]     s_axis_tdata,
  // stream out
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [7:0] red, [15:8] green, [23:16] blue
  output logic [23:0]                           m_axis_tdata,
  // register writes
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]                  cfg_index_i,
  input  logic [COORD_BITS-1:0]                 cfg_data_i
);

  localparam int CB  = COORD_BITS;
  localparam int SW  = COORD_BITS + 1;
  localparam int S3W = COORD_BITS + 10;
  localparam int QB  = POS_INT_BITS + HUE_FRAC_BITS;

  // range ends carry one extra bit so that the reset values always fit
  localparam logic [SW-1:0] LOW_RST  = SW'(RANGE_LOW_RST);
  localparam logic [SW-1:0] HIGH_RST = SW'(RANGE_HIGH_RST);

  logic [SW-1:0]   low_q, high_q;
  logic [SW:0]     span_diff;
  logic [SW-1:0]   span_d, span_q;
  logic [S3W-1:0]  span359_d, span359_q;

  logic            pipe_en;
  dhcm_ctl_t       front_ctl, div_ctl;
  logic [CB+8:0]   front_num;
  logic [QB-1:0]   div_quo;
  logic            rgb_vld;
  dhcm_rgb_t       rgb_data;

  logic            out_vld_q, skid_vld_q;
  dhcm_rgb_t       out_q, skid_q;
  logic            out_take;

  // ---------------------------------------------------------------------
  // Range registers; writes are always taken
  // ---------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= LOW_RST;
      high_q <= HIGH_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_RANGE_LOW:  low_q  <= {cfg_data_i[CB-1], cfg_data_i};
        REG_RANGE_HIGH: high_q <= {cfg_data_i[CB-1], cfg_data_i};
        default: ;
      endcase
    end
  end

  // Span magnitude and 359 spans, held in flops: the user must change the ranges
  // only while the pipeline is empty; the block itself does not enforce it
  assign span_diff = {high_q[SW-1], high_q} - {low_q[SW-1], low_q};
  assign span_d    = span_diff[SW] ? SW'(-span_diff) : span_diff[SW-1:0];
  assign span359_d = S3W'(span_q) * S3W'(POS_MAX_DEG);

  always_ff @(posedge clk_i) begin
    span_q    <= span_d;
    span359_q <= span359_d;
  end

  // ---------------------------------------------------------------------
  // Pipeline; advance whenever the skid slot is free
  // ---------------------------------------------------------------------
  assign pipe_en       = !skid_vld_q;
  assign s_axis_tready = pipe_en;

  dhcm_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (pipe_en),
    .vld_i     (s_axis_tvalid),
    .ref_x_i   (s_axis_tdata[CB-1:0]),
    .off_x_i   (s_axis_tdata[2*CB-1:CB]),
    .low_i     (low_q),
    .span_i    (span_q),
    .span359_i (span359_q),
    .ctl_o     (front_ctl),
    .num_o     (front_num)
  );

  dhcm_div #(
    .COORD_BITS    (COORD_BITS),
    .HUE_FRAC_BITS (HUE_FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .ctl_i  (front_ctl),
    .num_i  (front_num),
    .span_i (span_q),
    .ctl_o  (div_ctl),
    .quo_o  (div_quo)
  );

  dhcm_rgb #(
    .HUE_FRAC_BITS (HUE_FRAC_BITS)
  ) u_rgb (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .ctl_i  (div_ctl),
    .quo_i  (div_quo),
    .vld_o  (rgb_vld),
    .rgb_o  (rgb_data)
  );

  // ---------------------------------------------------------------------
  // Output register and skid slot
  // ---------------------------------------------------------------------
  assign out_take = out_vld_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      // pipeline frozen: drain the parked result once the output moves
      if (out_take) begin
        skid_vld_q <= 1'b0;
      end
    end else if (!out_vld_q || out_take) begin
      out_vld_q <= rgb_vld;
    end else if (rgb_vld) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (!out_vld_q || out_take) begin
      out_q <= rgb_data;
    end else begin
      skid_q <= rgb_data;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid slot holds a result while the output register is empty");

  a_skid_fill_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(out_vld_q && !m_axis_tready))
    else $error("skid slot filled without a stalled output");

  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q && m_axis_tready |=> !skid_vld_q)
    else $error("skid slot did not drain after the output moved");

  a_full_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (out_q.red == 8'(COLOUR_MAX) || out_q.green == 8'(COLOUR_MAX) ||
       out_q.blue == 8'(COLOUR_MAX)) &&
      (out_q.red == 8'd0 || out_q.green == 8'd0 || out_q.blue == 8'd0))
    else $error("colour lacks a full channel or an empty channel");

endmodule

`default_nettype wire
